// ----- src/pidc_pkg.sv -----
// Shared types and constants of the PID regulator.
package pidc_pkg;

	localparam int DATA_W    = 32;  // target, measured, error, drive
	localparam int GAIN_W    = 24;
	localparam int TIME_W    = 16;
	localparam int RATE_W    = 24;
	localparam int RATE_FRAC = 8;
	localparam int SUM_W     = 48;  // integral
	localparam int SPLIT     = 24;  // operand A split for two multiplier passes
	localparam int OPA_W     = 49;  // magnitude of operand A
	localparam int OPB_W     = 25;  // magnitude of operand B
	localparam int PROD_W    = 50;
	localparam int TERM_SH   = 40;  // products saturate at +-2^TERM_SH
	localparam int TERM_W    = 42;
	localparam int ADDR_W    = 5;
	localparam int PDATA_W   = 32;
	localparam int STEP_W    = 4;

	localparam logic [TIME_W-1:0] STEP_TIME_RST = 16'd1311;
	localparam logic [RATE_W-1:0] STEP_RATE_RST = 24'd12800;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_STEP_TIME,
		REG_STEP_RATE
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [TIME_W-1:0]        step_time;
		logic [RATE_W-1:0]        step_rate;
	} cfg_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {A_ERR, A_DIFF, A_SUM, A_DERIV} asel_t;
	typedef enum logic [2:0] {B_TIME, B_RATE, B_GP, B_GI, B_GD} bsel_t;
	typedef enum logic [2:0] {D_NONE, D_INC, D_DERIV, D_TP, D_TI, D_TD} dst_t;
	typedef enum logic [1:0] {J_NEXT, J_IN, J_OUT} jmp_t;

	// One microcode word.
	typedef struct packed {
		logic  load;    // take input item, form error
		logic  diff;    // form error difference, update last error
		logic  mul;     // multiplier pass
		logic  mul_hi;  // upper half of operand A
		logic  cap;     // round low partial product, latch sign and scale
		asel_t a;
		bsel_t b;
		logic  rate;    // scale is RATE_FRAC instead of FRAC_BITS
		dst_t  fin;     // finish product into this term register
		logic  acc;     // integral += increment
		logic  drive;   // sum terms into output register
		jmp_t  jmp;
		step_t tgt;
	} ctl_t;

endpackage

// ----- src/pidc_in_if.sv -----
// Input channel: target and measured value.
interface pidc_in_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] target;
	logic signed [DATA_W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

// ----- src/pidc_out_if.sv -----
// Output channel: drive and clip flag.
interface pidc_out_if;
	import pidc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic                     clipped;

	modport source (output valid, output drive, output clipped, input ready);
	modport sink (input valid, input drive, input clipped, output ready);
endinterface

// ----- src/pidc_regs.sv -----
// APB register file for gains and period settings.
module pidc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pidc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output pidc_pkg::cfg_t                cfg
);
	import pidc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.step_time <= STEP_TIME_RST;
			cfg_q.step_rate <= STEP_RATE_RST;
		end else if (wr) begin
			unique case (idx)
				REG_GAIN_P:    cfg_q.gain_p    <= signed'(pwdata[GAIN_W-1:0]);
				REG_GAIN_I:    cfg_q.gain_i    <= signed'(pwdata[GAIN_W-1:0]);
				REG_GAIN_D:    cfg_q.gain_d    <= signed'(pwdata[GAIN_W-1:0]);
				REG_STEP_TIME: cfg_q.step_time <= pwdata[TIME_W-1:0];
				REG_STEP_RATE: cfg_q.step_rate <= pwdata[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN_P:    prdata = PDATA_W'(unsigned'(cfg_q.gain_p));
			REG_GAIN_I:    prdata = PDATA_W'(unsigned'(cfg_q.gain_i));
			REG_GAIN_D:    prdata = PDATA_W'(unsigned'(cfg_q.gain_d));
			REG_STEP_TIME: prdata = PDATA_W'(cfg_q.step_time);
			REG_STEP_RATE: prdata = PDATA_W'(cfg_q.step_rate);
			default:       prdata = '0;
		endcase
	end
endmodule

// ----- src/pidc_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
module pidc_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_free,
	output pidc_pkg::ctl_t ctl
);
	import pidc_pkg::*;

	step_t step_q;
	step_t step_d;

	// Products overlap: the finish of one product shares a step with the
	// low pass of the next.
	function automatic ctl_t prog(input step_t s);
		ctl_t w;
		w = '0;
		unique case (s)
			4'd0: begin
				w.load = 1'b1;
				w.jmp  = J_IN;
			end
			4'd1: w.diff = 1'b1;
			4'd2: begin
				w.mul = 1'b1; w.a = A_ERR; w.b = B_TIME;
			end
			4'd3: begin
				w.mul = 1'b1; w.mul_hi = 1'b1; w.cap = 1'b1; w.a = A_ERR; w.b = B_TIME;
			end
			4'd4: begin
				w.fin = D_INC; w.mul = 1'b1; w.a = A_DIFF; w.b = B_RATE;
			end
			4'd5: begin
				w.mul = 1'b1; w.mul_hi = 1'b1; w.cap = 1'b1; w.a = A_DIFF; w.b = B_RATE;
				w.rate = 1'b1; w.acc = 1'b1;
			end
			4'd6: begin
				w.fin = D_DERIV; w.mul = 1'b1; w.a = A_ERR; w.b = B_GP;
			end
			4'd7: begin
				w.mul = 1'b1; w.mul_hi = 1'b1; w.cap = 1'b1; w.a = A_ERR; w.b = B_GP;
			end
			4'd8: begin
				w.fin = D_TP; w.mul = 1'b1; w.a = A_SUM; w.b = B_GI;
			end
			4'd9: begin
				w.mul = 1'b1; w.mul_hi = 1'b1; w.cap = 1'b1; w.a = A_SUM; w.b = B_GI;
			end
			4'd10: begin
				w.fin = D_TI; w.mul = 1'b1; w.a = A_DERIV; w.b = B_GD;
			end
			4'd11: begin
				w.mul = 1'b1; w.mul_hi = 1'b1; w.cap = 1'b1; w.a = A_DERIV; w.b = B_GD;
			end
			4'd12: w.fin = D_TD;
			4'd13: begin
				w.drive = 1'b1;
				w.jmp   = J_OUT;
				w.tgt   = '0;
			end
			default: begin
				w.jmp = J_OUT;
				w.tgt = '0;
			end
		endcase
		return w;
	endfunction

	assign ctl = prog(step_q);

	always_comb begin
		unique case (ctl.jmp)
			J_NEXT:  step_d = step_q + 1'b1;
			J_IN:    step_d = in_valid ? step_q + 1'b1 : step_q;
			J_OUT:   step_d = out_free ? ctl.tgt : step_q;
			default: step_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end
endmodule

// ----- src/pidc_dp.sv -----
// Datapath: error, shared multiplier with rounding, integral and drive sum.
module pidc_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pidc_pkg::ctl_t                   ctl,
	input  pidc_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	input  logic signed [pidc_pkg::DATA_W-1:0] target,
	input  logic signed [pidc_pkg::DATA_W-1:0] measured,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic signed [pidc_pkg::DATA_W-1:0] drive,
	output logic                             clipped,
	output logic                             out_free
);
	import pidc_pkg::*;

	localparam int FUP = SPLIT - FRAC_BITS;
	localparam int RUP = SPLIT - RATE_FRAC;
	localparam logic [PROD_W-1:0] F_THR = PROD_W'(1) << (TERM_SH - SPLIT + FRAC_BITS);
	localparam logic [PROD_W-1:0] R_THR = PROD_W'(1) << (TERM_SH - SPLIT + RATE_FRAC);
	localparam logic [PROD_W-1:0] F_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] R_HALF = PROD_W'(1) << (RATE_FRAC - 1);
	localparam logic [TERM_W-1:0] LIM = TERM_W'(1) << TERM_SH;
	localparam logic signed [DATA_W:0] D_MAX = (DATA_W+1)'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [DATA_W:0] D_MIN = (DATA_W+1)'({2'b11, {(DATA_W-1){1'b0}}});
	localparam int DSUM_W = TERM_W + 2;

	logic signed [DATA_W-1:0] err_q, last_q;
	logic signed [DATA_W:0]   diff_q;
	logic signed [SUM_W-1:0]  esum_q;
	logic signed [TERM_W-1:0] inc_q, deriv_q, tp_q, ti_q, td_q;
	logic [PROD_W-1:0]        prod_q;
	logic [TERM_W-1:0]        lornd_q;
	logic                     neg_q, rate_q;
	logic                     out_valid_q, clip_q;
	logic signed [DATA_W-1:0] drive_q;

	logic signed [DATA_W:0]   sub;
	logic signed [DATA_W-1:0] err_c;
	logic signed [OPA_W-1:0]  opa;
	logic signed [OPB_W-1:0]  opb;
	logic [OPA_W-1:0]         ua;
	logic [OPB_W-1:0]         ub;
	logic [OPB_W-1:0]         mfac;
	logic [PROD_W-1:0]        prod_c;
	logic [PROD_W-1:0]        lo_sum;
	logic [TERM_W-1:0]        lornd_c;
	logic                     ovf;
	logic [TERM_W-1:0]        hi_w, hi_sh, mag_sum, mag;
	logic signed [TERM_W-1:0] term;
	logic signed [SUM_W:0]    esum_ext;
	logic signed [DSUM_W-1:0] dsum;
	logic                     load;
	logic                     emit;

	assign load     = ctl.load && in_valid;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = ctl.drive && out_free;

	// error = sat32(target - measured)
	always_comb begin
		sub = (DATA_W+1)'(target) - (DATA_W+1)'(measured);
		if (sub > D_MAX)      err_c = D_MAX[DATA_W-1:0];
		else if (sub < D_MIN) err_c = D_MIN[DATA_W-1:0];
		else                  err_c = sub[DATA_W-1:0];
	end

	// operand select and magnitudes
	always_comb begin
		case (ctl.a)
			A_ERR:   opa = OPA_W'(err_q);
			A_DIFF:  opa = OPA_W'(diff_q);
			A_SUM:   opa = OPA_W'(esum_q);
			A_DERIV: opa = OPA_W'(deriv_q);
			default: opa = '0;
		endcase
		case (ctl.b)
			B_TIME:  opb = signed'({{(OPB_W-TIME_W){1'b0}}, cfg.step_time});
			B_RATE:  opb = signed'({{(OPB_W-RATE_W){1'b0}}, cfg.step_rate});
			B_GP:    opb = OPB_W'(cfg.gain_p);
			B_GI:    opb = OPB_W'(cfg.gain_i);
			B_GD:    opb = OPB_W'(cfg.gain_d);
			default: opb = '0;
		endcase
		ua     = opa[OPA_W-1] ? unsigned'(-opa) : unsigned'(opa);
		ub     = opb[OPB_W-1] ? unsigned'(-opb) : unsigned'(opb);
		mfac   = ctl.mul_hi ? ua[OPA_W-1:SPLIT] : {1'b0, ua[SPLIT-1:0]};
		prod_c = mfac * ub;
	end

	// low partial product rounded at its scale
	always_comb begin
		lo_sum  = prod_q + (ctl.rate ? R_HALF : F_HALF);
		lornd_c = ctl.rate ? TERM_W'(lo_sum >> RATE_FRAC) : TERM_W'(lo_sum >> FRAC_BITS);
	end

	// combine high partial product, saturate to +-2^40, apply sign
	always_comb begin
		ovf     = prod_q > (rate_q ? R_THR : F_THR);
		hi_w    = {1'b0, prod_q[TERM_SH:0]};
		hi_sh   = rate_q ? (hi_w << RUP) : (hi_w << FUP);
		mag_sum = hi_sh + lornd_q;
		mag     = (ovf || mag_sum > LIM) ? LIM : mag_sum;
		term    = neg_q ? -signed'(mag) : signed'(mag);
	end

	assign esum_ext = (SUM_W+1)'(esum_q) + (SUM_W+1)'(inc_q);
	assign dsum     = DSUM_W'(tp_q) + DSUM_W'(ti_q) + DSUM_W'(td_q);

	// architectural state and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esum_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.diff) begin
				last_q <= err_q;
			end
			if (ctl.acc) begin
				if (esum_ext[SUM_W] != esum_ext[SUM_W-1]) begin
					esum_q <= {esum_ext[SUM_W], {(SUM_W-1){!esum_ext[SUM_W]}}};
				end else begin
					esum_q <= esum_ext[SUM_W-1:0];
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			err_q <= err_c;
		end
		if (ctl.diff) begin
			diff_q <= (DATA_W+1)'(err_q) - (DATA_W+1)'(last_q);
		end
		if (ctl.mul) begin
			prod_q <= prod_c;
		end
		if (ctl.cap) begin
			lornd_q <= lornd_c;
			neg_q   <= opa[OPA_W-1] ^ opb[OPB_W-1];
			rate_q  <= ctl.rate;
		end
		case (ctl.fin)
			D_INC:   inc_q   <= term;
			D_DERIV: deriv_q <= term;
			D_TP:    tp_q    <= term;
			D_TI:    ti_q    <= term;
			D_TD:    td_q    <= term;
			default: ;
		endcase
		if (emit) begin
			if (dsum > DSUM_W'(D_MAX)) begin
				drive_q <= D_MAX[DATA_W-1:0];
				clip_q  <= 1'b1;
			end else if (dsum < DSUM_W'(D_MIN)) begin
				drive_q <= D_MIN[DATA_W-1:0];
				clip_q  <= 1'b1;
			end else begin
				drive_q <= dsum[DATA_W-1:0];
				clip_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clipped   = clip_q;
endmodule

// ----- src/pid_controller_unit.sv -----
// Top level of the microcoded fixed-point PID regulator.
//
//  channel  dir  handshake           payload
//  sample   in   valid / ready       target, measured (signed Q16.16)
//  result   out  valid / ready       drive (signed Q16.16, saturated), clipped
//  apb      in   psel/penable/pready gain_p, gain_i, gain_d, step_time, step_rate
//
// Sequence: an item is accepted only at the load step, and the next item is not
// accepted until the program has run through all of its steps. The steps follow
// from the single 25x25 multiplier: five products, two passes each, one
// finish step overlapped with the next product, plus load, difference and final
// sum steps.
// Reset clears the integral, the previous error, the registers (period and
// rate to their defaults) and the step counter; no clearing pass is needed.
// A finished result waits in the output register; the sequencer holds at its
// last step only while an earlier result is still untaken.
module pid_controller_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pidc_in_if.sink                       sample,
	pidc_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pidc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pidc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import pidc_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	logic out_free;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step counter and control ROM
	pidc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// input is taken only at the load step of the program
	assign sample.ready = ctl.load;

	pidc_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg),
		.in_valid  (sample.valid),
		.target    (sample.target),
		.measured  (sample.measured),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.drive     (result.drive),
		.clipped   (result.clipped),
		.out_free  (out_free)
	);

	// a clipped drive sits at one of the rails
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clipped |->
			(result.drive == 32'sh7fffffff || result.drive == 32'sh80000000))
		else $error("clipped drive not at a rail");

	// one item at a time: no input taken right after an acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("input taken on consecutive cycles");

	// a new result only comes out of the final sum step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(ctl.drive))
		else $error("result raised outside the sum step");
endmodule
